### src/chacha20_stream_cipher_top_assert.svh
// assertion macros for the chacha20 stream cipher block
`ifndef CHACHA20_STREAM_CIPHER_TOP_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CC_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

### src/cc20_pkg.sv
// shared types and constants for the chacha20 stream cipher
`default_nettype none
package cc20_pkg;
    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int RND_W = 5;
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646E;
    localparam logic [31:0] SIGMA2 = 32'h79622D32;
    localparam logic [31:0] SIGMA3 = 32'h6B206574;
    localparam logic [2:0] REG_KEY01 = 3'd0;
    localparam logic [2:0] REG_KEY23 = 3'd1;
    localparam logic [2:0] REG_KEY45 = 3'd2;
    localparam logic [2:0] REG_KEY67 = 3'd3;
    localparam logic [2:0] REG_NONCE01 = 3'd4;
    localparam logic [2:0] REG_NONCE2 = 3'd5;
    localparam logic [2:0] REG_CTRSTART = 3'd6;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // load initial state from config
        logic round;     // run one half double round
        logic diag;      // diagonal half when set
        logic finish;    // feed-forward add into keystream store
        logic restart;   // counter from counter_start, position zero
        logic use_word;  // consume a word, latch result
    } cc20_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic block_ready;
    } cc20_sts_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    typedef logic [31:0] qr_t [4];

    function automatic qr_t qround(input logic [31:0] a, input logic [31:0] b,
                                   input logic [31:0] c, input logic [31:0] d);
        logic [31:0] ta, tb, tc, td;
        qr_t r;
        ta = a + b; td = rotl(d ^ ta, 16);
        tc = c + td; tb = rotl(b ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        r[0] = ta; r[1] = tb; r[2] = tc; r[3] = td;
        return r;
    endfunction
endpackage
`default_nettype wire

### src/cc20_ctrl.sv
// controller state machine for block generation and word handling
`default_nettype none
module cc20_ctrl #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic                msg_start,
    input  wire logic                m_tready,
    output logic                     m_tvalid,
    output cc20_pkg::cc20_cmd_t      cmd,
    input  wire cc20_pkg::cc20_sts_t sts
);
    import cc20_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINISH} state_t;
    localparam int HALF = 2 * DOUBLE_ROUNDS;
    localparam int HW = $clog2(HALF + 1);

    state_t state_reg, state_next;
    logic [HW-1:0] cnt_reg, cnt_next;
    logic mvalid_reg, mvalid_next;
    logic take;

    // accept while idle and output slot free or draining
    assign s_tready = (state_reg == ST_IDLE) && (!mvalid_reg || m_tready);
    assign take = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (msg_start || !sts.block_ready) begin
                        cmd.load = 1'b1;
                        cmd.restart = msg_start;
                        cnt_next = '0;
                        state_next = ST_ROUND;
                    end else begin
                        cmd.use_word = 1'b1;
                        mvalid_next = 1'b1;
                    end
                end
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                cmd.diag = cnt_reg[0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == HW'(HALF - 1)) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                cmd.use_word = 1'b1;
                mvalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule
`default_nettype wire

### src/cc20_dp.sv
// datapath: config registers, round state, keystream store, output word
`default_nettype none
module cc20_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [5:0]          paddr,
    input  wire logic [63:0]         pwdata,
    output logic [63:0]              prdata,
    input  wire logic                s_take,
    input  wire logic [31:0]         data_word,
    input  wire logic [2:0]          byte_count,
    input  wire cc20_pkg::cc20_cmd_t cmd,
    output cc20_pkg::cc20_sts_t      sts,
    output logic [31:0]              out_word,
    output logic [2:0]               out_byte_count
);
    import cc20_pkg::*;

    logic [63:0] key01_reg, key23_reg, key45_reg, key67_reg, non01_reg;
    logic [31:0] non2_reg, cstart_reg;
    logic [31:0] ctr_reg;
    logic [3:0]  pos_reg;
    logic        rdy_reg;
    logic [31:0] work_reg [16];
    logic [31:0] ks_reg [16];
    logic [31:0] init_w [16];
    logic [31:0] rnd_w [16];
    logic [31:0] din_reg;
    logic [2:0]  cnt_reg;
    logic [31:0] ow_reg;
    logic [2:0]  obc_reg;
    logic [31:0] ctr_use;
    logic [31:0] ks_word;
    logic [2:0]  cnt_sat;
    logic [31:0] mask;
    logic        wr;
    logic [2:0]  ridx;

    assign wr = psel && penable && pwrite;
    assign ridx = paddr[5:3];

    // register read
    always_comb begin
        case (ridx)
            REG_KEY01:    prdata = key01_reg;
            REG_KEY23:    prdata = key23_reg;
            REG_KEY45:    prdata = key45_reg;
            REG_KEY67:    prdata = key67_reg;
            REG_NONCE01:  prdata = non01_reg;
            REG_NONCE2:   prdata = {32'd0, non2_reg};
            REG_CTRSTART: prdata = {32'd0, cstart_reg};
            default:      prdata = '0;
        endcase
    end

    // register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key01_reg <= '0; key23_reg <= '0; key45_reg <= '0; key67_reg <= '0;
            non01_reg <= '0; non2_reg <= '0; cstart_reg <= '0;
        end else if (wr) begin
            case (ridx)
                REG_KEY01:    key01_reg <= pwdata;
                REG_KEY23:    key23_reg <= pwdata;
                REG_KEY45:    key45_reg <= pwdata;
                REG_KEY67:    key67_reg <= pwdata;
                REG_NONCE01:  non01_reg <= pwdata;
                REG_NONCE2:   non2_reg <= pwdata[31:0];
                REG_CTRSTART: cstart_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // initial state, counter taken from start on restart
    assign ctr_use = cmd.restart ? cstart_reg : ctr_reg;
    always_comb begin
        init_w[0] = SIGMA0; init_w[1] = SIGMA1; init_w[2] = SIGMA2; init_w[3] = SIGMA3;
        init_w[4] = key01_reg[31:0];  init_w[5] = key01_reg[63:32];
        init_w[6] = key23_reg[31:0];  init_w[7] = key23_reg[63:32];
        init_w[8] = key45_reg[31:0];  init_w[9] = key45_reg[63:32];
        init_w[10] = key67_reg[31:0]; init_w[11] = key67_reg[63:32];
        init_w[12] = ctr_use;
        init_w[13] = non01_reg[31:0]; init_w[14] = non01_reg[63:32];
        init_w[15] = non2_reg;
    end

    // one half double round: four quarter rounds in parallel
    always_comb begin
        qr_t q;
        rnd_w = work_reg;
        for (int i = 0; i < 4; i++) begin
            if (!cmd.diag) begin
                q = qround(work_reg[i], work_reg[4+i], work_reg[8+i], work_reg[12+i]);
                rnd_w[i] = q[0]; rnd_w[4+i] = q[1]; rnd_w[8+i] = q[2]; rnd_w[12+i] = q[3];
            end else begin
                q = qround(work_reg[i], work_reg[4+((i+1)%4)], work_reg[8+((i+2)%4)],
                           work_reg[12+((i+3)%4)]);
                rnd_w[i] = q[0]; rnd_w[4+((i+1)%4)] = q[1];
                rnd_w[8+((i+2)%4)] = q[2]; rnd_w[12+((i+3)%4)] = q[3];
            end
        end
    end

    // round state and keystream store
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < 16; i++) work_reg[i] <= init_w[i];
        end else if (cmd.round) begin
            work_reg <= rnd_w;
        end
        if (cmd.finish) begin
            for (int i = 0; i < 16; i++) ks_reg[i] <= work_reg[i] + init_w[i];
        end
        if (s_take) begin
            din_reg <= data_word;
            cnt_reg <= byte_count;
        end
    end

    // counter, position, ready flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg <= '0;
            pos_reg <= '0;
            rdy_reg <= 1'b0;
        end else begin
            if (cmd.load && cmd.restart) begin
                ctr_reg <= cstart_reg;
                pos_reg <= '0;
            end
            if (cmd.finish) rdy_reg <= 1'b1;
            if (cmd.use_word) begin
                pos_reg <= pos_reg + 4'd1;
                if (pos_reg == 4'd15) begin
                    ctr_reg <= ctr_reg + 32'd1;
                    rdy_reg <= 1'b0;
                end
            end
        end
    end

    // keystream word: fresh sum on the finish cycle
    assign ks_word = cmd.finish ? (work_reg[pos_reg] + init_w[pos_reg]) : ks_reg[pos_reg];
    logic [31:0] dsel;
    logic [2:0]  csel;
    assign dsel = cmd.finish ? din_reg : data_word;
    assign csel = cmd.finish ? cnt_reg : byte_count;
    assign cnt_sat = (csel > 3'd4) ? 3'd4 : csel;
    always_comb begin
        case (cnt_sat)
            3'd0: mask = 32'h0000_0000;
            3'd1: mask = 32'h0000_00FF;
            3'd2: mask = 32'h0000_FFFF;
            3'd3: mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.use_word) begin
            ow_reg <= (dsel ^ ks_word) & mask;
            obc_reg <= cnt_sat;
        end
    end

    assign sts.block_ready = rdy_reg;
    assign out_word = ow_reg;
    assign out_byte_count = obc_reg;
endmodule
`default_nettype wire

### src/chacha20_stream_cipher_top.sv
// top level of the chacha20 stream cipher block
// Usage:
//   s_ channel takes one 32-bit data word per request with byte count and a
//   message start flag in tuser; m_ channel returns the XORed word and its
//   byte count. Key, nonce and starting counter come through the APB port.
//   A word that finds a keystream block ready is XORed straight into the output
//   register. A word that needs a new block (message start, or every 16th
//   word) loads the state at acceptance, then runs 2*DOUBLE_ROUNDS half
//   rounds on the single four-lane quarter-round unit and the feed-forward
//   add, which also writes its output word. One item is in flight at a time.
//   Reset clears the config registers, counter and word position; the first block
//   after reset uses counter zero unless a message start is seen.
//   When m_tready is low the result holds in the output register, and a new
//   request is taken only once that register is free or draining.
`default_nettype none
`include "chacha20_stream_cipher_top_assert.svh"
module chacha20_stream_cipher_top #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // data_word
    input  wire logic [3:0]  s_tuser,  // byte_count[2:0], msg_start[3]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // out_word
    output logic [2:0]       m_tuser   // out_byte_count
);
    import cc20_pkg::*;

    cc20_cmd_t cmd;
    cc20_sts_t sts;
    logic take;

    assign pready = 1'b1;
    assign take = s_tvalid && s_tready;

    // controller
    cc20_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .msg_start(s_tuser[3]), .m_tready(m_tready), .m_tvalid(m_tvalid),
        .cmd(cmd), .sts(sts)
    );

    // datapath
    cc20_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .s_take(take), .data_word(s_tdata), .byte_count(s_tuser[2:0]),
        .cmd(cmd), .sts(sts), .out_word(m_tdata), .out_byte_count(m_tuser)
    );

    // checks
    `CC_ASSERT_NXT(a_round_follows_load, aclk, aresetn, cmd.load, cmd.round)
    `CC_ASSERT_IMP(a_no_take_busy, aclk, aresetn, cmd.round || cmd.finish, !s_tready)
    `CC_ASSERT_NXT(a_word_valid, aclk, aresetn, cmd.use_word, m_tvalid)
endmodule
`default_nettype wire
